// ===== src/sprite_screen_projection_assert.svh =====
// Assertion macros for the sprite screen projection block.
// Included by sprite_screen_projection.sv, which checks its own logic; needs nothing else.
`ifndef SPRITE_SCREEN_PROJECTION_ASSERT_SVH
`define SPRITE_SCREEN_PROJECTION_ASSERT_SVH
`ifndef SYNTHESIS
`define SSP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssp: same-cycle check failed");
`define SSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssp: next-cycle check failed");
`else
`define SSP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SSP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/ssp_pkg.sv =====
// Package of the sprite screen projection block: widths, reset values and
// register index codes. Depends on nothing.
package ssp_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int MAX_SCREEN = 4096;

   localparam int POS_W   = 24;
   localparam int DIR_W   = 19;
   localparam int SCR_W   = 13;
   localparam int DIFF_W  = POS_W + 1;
   localparam int PROD_W  = DIR_W + DIFF_W;
   localparam int NUM_W   = PROD_W + 1;
   localparam int MAG_W   = NUM_W - 1;
   localparam int DETP_W  = 2 * DIR_W;
   localparam int DET_W   = DETP_W + 1;
   localparam int DMAG_W  = DET_W - 1;
   localparam int TNUM_W  = MAG_W + FRAC_BITS;
   localparam int TQ_W    = POS_W;
   localparam int COL_W   = 20;
   localparam int SIZE_W  = 19;
   localparam int CQ_W    = COL_W;
   localparam int SUM_W   = POS_W + 1;
   localparam int HALF_W  = SCR_W - 1;
   localparam int CPROD_W = SUM_W + HALF_W;
   localparam int TYD_W   = POS_W - 1;
   localparam int SNUM_W  = SCR_W + FRAC_BITS;
   localparam int ROW_W   = 12;
   localparam int BND_W   = COL_W + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = POS_W;

   localparam logic signed [DIR_W-1:0] DIR_X_RST   = -19'sd65536;
   localparam logic signed [DIR_W-1:0] PLANE_Y_RST = 19'sd43254;
   localparam logic [SCR_W-1:0]        SCR_W_RST   = 13'd640;
   localparam logic [SCR_W-1:0]        SCR_H_RST   = 13'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POS_X, CSR_POS_Y, CSR_DIR_X, CSR_DIR_Y,
      CSR_PLANE_X, CSR_PLANE_Y, CSR_SCR_W, CSR_SCR_H
   } csr_index_type;

endpackage

// ===== src/ssp_req_if.sv =====
// Input channel of the sprite screen projection block: one sprite position.
// Depends on ssp_pkg.
interface ssp_req_if;
   import ssp_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] sprite_x;
   logic signed [POS_W-1:0] sprite_y;
   modport source (output valid, sprite_x, sprite_y, input ready);
   modport sink (input valid, sprite_x, sprite_y, output ready);
endinterface

// ===== src/ssp_rsp_if.sv =====
// Result channel of the sprite screen projection block: column, size, bounds.
// Depends on ssp_pkg.
interface ssp_rsp_if;
   import ssp_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [COL_W-1:0] screen_column;
   logic [SIZE_W-1:0]       sprite_size;
   logic [SIZE_W-1:0]       draw_start_x;
   logic signed [COL_W-1:0] draw_end_x;
   logic [ROW_W-1:0]        draw_start_y;
   logic [ROW_W-1:0]        draw_end_y;
   logic signed [POS_W-1:0] view_depth;
   logic signed [POS_W-1:0] transform_x;
   logic                    camera_singular;
   logic                    not_in_front;
   modport source (output valid, screen_column, sprite_size, draw_start_x, draw_end_x,
                   draw_start_y, draw_end_y, view_depth, transform_x, camera_singular,
                   not_in_front, input ready);
   modport sink (input valid, screen_column, sprite_size, draw_start_x, draw_end_x,
                 draw_start_y, draw_end_y, view_depth, transform_x, camera_singular,
                 not_in_front, output ready);
endinterface

// ===== src/ssp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Self-contained; instanced by the sprite screen projection top level.
module ssp_div #(
   parameter int NUM_W  = 8,
   parameter int DEN_W  = 8,
   parameter int QUO_W  = 8,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [QUO_W-1:0]  quot,
   output logic              ovf,
   output logic [SIDE_W-1:0] side_out
);
   localparam int REM_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

   logic              vld_ff  [QUO_W];
   logic [REM_W-1:0]  rem_ff  [QUO_W];
   logic [REM_W-1:0]  den_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic              ovf_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic              vld_cur;
      logic [REM_W-1:0]  rem_cur;
      logic [REM_W-1:0]  den_cur;
      logic [QUO_W-1:0]  quo_cur;
      logic              ovf_cur;
      logic [SIDE_W-1:0] side_cur;
      logic [REM_W-1:0]  shifted;
      logic              fits;
      logic [REM_W-1:0]  rem_in;
      logic [QUO_W-1:0]  quo_in;

      if (k == 0) begin : g_first
         // The quotient overflows its width when the numerator reaches den << QUO_W.
         assign vld_cur  = in_valid;
         assign rem_cur  = REM_W'(num);
         assign den_cur  = REM_W'(den);
         assign quo_cur  = '0;
         assign ovf_cur  = REM_W'(num) >= (REM_W'(den) << QUO_W);
         assign side_cur = side_in;
      end else begin : g_next
         assign vld_cur  = vld_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign den_cur  = den_ff[k-1];
         assign quo_cur  = quo_ff[k-1];
         assign ovf_cur  = ovf_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      assign shifted = den_cur << (QUO_W - 1 - k);
      assign fits    = rem_cur >= shifted;
      assign rem_in  = fits ? (rem_cur - shifted) : rem_cur;
      assign quo_in  = quo_cur | (fits ? (QUO_W'(1) << (QUO_W - 1 - k)) : '0);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (enable) begin
            vld_ff[k] <= vld_cur;
         end
         if (enable) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_cur;
            quo_ff[k]  <= quo_in;
            ovf_ff[k]  <= ovf_cur;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign quot      = quo_ff[QUO_W-1];
   assign ovf       = ovf_ff[QUO_W-1];
   assign side_out  = side_ff[QUO_W-1];

endmodule

// ===== src/sprite_screen_projection.sv =====
// Accepts one sprite per cycle unless a finished result waits on the output.
// The 24-stage and 20-stage divider pipelines set most of the latency; every stage
// moves together and holds while a finished result waits on the output.
// Reset (synchronous, active high) empties the pipeline and loads the default
// camera: direction (-1, 0), plane (0, 0.66), screen 640 by 480.
`include "sprite_screen_projection_assert.svh"
module sprite_screen_projection (
   input logic                            clock,
   input logic                            reset,
   ssp_req_if.sink                        req,
   ssp_rsp_if.source                      rsp,
   input logic                            csr_we,
   input logic [ssp_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [ssp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ssp_pkg::*;

   // Configuration registers.
   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff;
   logic signed [DIR_W-1:0] dir_x_ff, dir_y_ff, pln_x_ff, pln_y_ff;
   logic [SCR_W-1:0]        scr_w_ff, scr_h_ff;
   logic [SCR_W-1:0]        w_eff, h_eff;
   logic [HALF_W-1:0]       half_w, half_h;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         dir_x_ff <= DIR_X_RST;
         dir_y_ff <= '0;
         pln_x_ff <= '0;
         pln_y_ff <= PLANE_Y_RST;
         scr_w_ff <= SCR_W_RST;
         scr_h_ff <= SCR_H_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POS_X:   pos_x_ff <= csr_wdata[POS_W-1:0];
            CSR_POS_Y:   pos_y_ff <= csr_wdata[POS_W-1:0];
            CSR_DIR_X:   dir_x_ff <= csr_wdata[DIR_W-1:0];
            CSR_DIR_Y:   dir_y_ff <= csr_wdata[DIR_W-1:0];
            CSR_PLANE_X: pln_x_ff <= csr_wdata[DIR_W-1:0];
            CSR_PLANE_Y: pln_y_ff <= csr_wdata[DIR_W-1:0];
            CSR_SCR_W:   scr_w_ff <= csr_wdata[SCR_W-1:0];
            CSR_SCR_H:   scr_h_ff <= csr_wdata[SCR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_eff = (scr_w_ff == '0) ? SCR_W'(1) :
              (scr_w_ff > SCR_W'(MAX_SCREEN)) ? SCR_W'(MAX_SCREEN) : scr_w_ff;
      h_eff = (scr_h_ff == '0) ? SCR_W'(1) :
              (scr_h_ff > SCR_W'(MAX_SCREEN)) ? SCR_W'(MAX_SCREEN) : scr_h_ff;
      half_w = w_eff[SCR_W-1:1];
      half_h = h_eff[SCR_W-1:1];
   end

   // The whole pipeline advances together unless the output holds a result.
   logic adv;
   logic out_vld_ff;
   assign adv       = !out_vld_ff || rsp.ready;
   assign req.ready = adv;

   // Stage 1: offset from the camera.
   logic                     s1_vld_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   // Stage 2: products.
   logic                     s2_vld_ff;
   logic signed [PROD_W-1:0] pxa_ff, pxb_ff, pya_ff, pyb_ff;
   logic signed [DETP_W-1:0] pda_ff, pdb_ff;
   // Stage 3: numerators and determinant.
   logic                     s3_vld_ff;
   logic signed [NUM_W-1:0]  numx_ff, numy_ff;
   logic signed [DET_W-1:0]  det_ff;
   // Stage 4: magnitudes and signs.
   logic                     s4_vld_ff;
   logic [MAG_W-1:0]         magx_ff, magy_ff;
   logic [DMAG_W-1:0]        dmag_ff;
   logic                     negx_ff, negy_ff, sing4_ff;
   logic [NUM_W-1:0]         absx, absy;
   logic [DET_W-1:0]         absd;

   always_comb begin
      absx = numx_ff[NUM_W-1] ? NUM_W'(-numx_ff) : NUM_W'(numx_ff);
      absy = numy_ff[NUM_W-1] ? NUM_W'(-numy_ff) : NUM_W'(numy_ff);
      absd = det_ff[DET_W-1] ? DET_W'(-det_ff) : DET_W'(det_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
      if (adv) begin
         dx_ff   <= DIFF_W'(req.sprite_x) - DIFF_W'(pos_x_ff);
         dy_ff   <= DIFF_W'(req.sprite_y) - DIFF_W'(pos_y_ff);
         pxa_ff  <= PROD_W'(dir_y_ff) * PROD_W'(dx_ff);
         pxb_ff  <= PROD_W'(dir_x_ff) * PROD_W'(dy_ff);
         pya_ff  <= PROD_W'(pln_x_ff) * PROD_W'(dy_ff);
         pyb_ff  <= PROD_W'(pln_y_ff) * PROD_W'(dx_ff);
         pda_ff  <= DETP_W'(pln_x_ff) * DETP_W'(dir_y_ff);
         pdb_ff  <= DETP_W'(dir_x_ff) * DETP_W'(pln_y_ff);
         numx_ff <= NUM_W'(pxa_ff) - NUM_W'(pxb_ff);
         numy_ff <= NUM_W'(pya_ff) - NUM_W'(pyb_ff);
         det_ff  <= DET_W'(pda_ff) - DET_W'(pdb_ff);
         magx_ff <= absx[MAG_W-1:0];
         magy_ff <= absy[MAG_W-1:0];
         negx_ff <= numx_ff[NUM_W-1] ^ det_ff[DET_W-1];
         negy_ff <= numy_ff[NUM_W-1] ^ det_ff[DET_W-1];
         sing4_ff <= (det_ff == '0);
         // A singular camera divides by one; its quotients are discarded.
         dmag_ff <= (det_ff == '0) ? DMAG_W'(1) : absd[DMAG_W-1:0];
      end
   end

   // Transform division: lateral offset and depth, each scaled by 2^FRAC_BITS.
   logic              dxv, dyv, qx_ovf, qy_ovf;
   logic [TQ_W-1:0]   qx, qy;
   logic [1:0]        dx_side;
   logic              dy_side;

   ssp_div #(.NUM_W(TNUM_W), .DEN_W(DMAG_W), .QUO_W(TQ_W), .SIDE_W(2)) u_div_tx (
      .clock(clock), .reset(reset), .enable(adv), .in_valid(s4_vld_ff),
      .num({magx_ff, FRAC_BITS'(0)}), .den(dmag_ff), .side_in({sing4_ff, negx_ff}),
      .out_valid(dxv), .quot(qx), .ovf(qx_ovf), .side_out(dx_side)
   );

   ssp_div #(.NUM_W(TNUM_W), .DEN_W(DMAG_W), .QUO_W(TQ_W), .SIDE_W(1)) u_div_ty (
      .clock(clock), .reset(reset), .enable(adv), .in_valid(s4_vld_ff),
      .num({magy_ff, FRAC_BITS'(0)}), .den(dmag_ff), .side_in(negy_ff),
      .out_valid(dyv), .quot(qy), .ovf(qy_ovf), .side_out(dy_side)
   );

   localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

   logic [POS_W-1:0] tx_sat, ty_sat;

   always_comb begin
      if (dx_side[0]) begin
         tx_sat = (qx_ovf || (qx[TQ_W-1] && (|qx[TQ_W-2:0]))) ? POS_MIN : (~qx) + POS_W'(1);
      end else begin
         tx_sat = (qx_ovf || qx[TQ_W-1]) ? POS_MAX : qx;
      end
      if (dy_side) begin
         ty_sat = (qy_ovf || (qy[TQ_W-1] && (|qy[TQ_W-2:0]))) ? POS_MIN : (~qy) + POS_W'(1);
      end else begin
         ty_sat = (qy_ovf || qy[TQ_W-1]) ? POS_MAX : qy;
      end
   end

   // B1: saturated offset and depth. B2: sum and divisor. B3: magnitude.
   // B4: product with half the screen width.
   logic                     b1_vld_ff, b2_vld_ff, b3_vld_ff, b4_vld_ff;
   logic signed [POS_W-1:0]  tx1_ff, ty1_ff, tx2_ff, ty2_ff, tx3_ff, ty3_ff, tx4_ff, ty4_ff;
   logic                     sing1_ff, sing2_ff, sing3_ff, sing4b_ff;
   logic                     nif1_ff, nif2_ff, nif3_ff, nif4_ff;
   logic signed [SUM_W-1:0]  sum2_ff;
   logic [TYD_W-1:0]         den2_ff, den3_ff, den4_ff;
   logic [SUM_W-1:0]         smag3_ff;
   logic                     sneg3_ff, sneg4_ff;
   logic [CPROD_W-1:0]       cprod4_ff;
   logic                     nif_in;

   assign nif_in = !dx_side[1] && (ty_sat[POS_W-1] || (ty_sat == '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff <= 1'b0;
         b2_vld_ff <= 1'b0;
         b3_vld_ff <= 1'b0;
         b4_vld_ff <= 1'b0;
      end else if (adv) begin
         b1_vld_ff <= dxv && dyv;
         b2_vld_ff <= b1_vld_ff;
         b3_vld_ff <= b2_vld_ff;
         b4_vld_ff <= b3_vld_ff;
      end
      if (adv) begin
         tx1_ff    <= tx_sat;
         ty1_ff    <= ty_sat;
         sing1_ff  <= dx_side[1];
         nif1_ff   <= nif_in;
         tx2_ff    <= tx1_ff;
         ty2_ff    <= ty1_ff;
         sing2_ff  <= sing1_ff;
         nif2_ff   <= nif1_ff;
         sum2_ff   <= SUM_W'(tx1_ff) + SUM_W'(ty1_ff);
         den2_ff   <= (sing1_ff || nif1_ff) ? TYD_W'(1) : ty1_ff[TYD_W-1:0];
         tx3_ff    <= tx2_ff;
         ty3_ff    <= ty2_ff;
         sing3_ff  <= sing2_ff;
         nif3_ff   <= nif2_ff;
         den3_ff   <= den2_ff;
         smag3_ff  <= sum2_ff[SUM_W-1] ? SUM_W'(-sum2_ff) : SUM_W'(sum2_ff);
         sneg3_ff  <= sum2_ff[SUM_W-1];
         tx4_ff    <= tx3_ff;
         ty4_ff    <= ty3_ff;
         sing4b_ff <= sing3_ff;
         nif4_ff   <= nif3_ff;
         den4_ff   <= den3_ff;
         sneg4_ff  <= sneg3_ff;
         cprod4_ff <= CPROD_W'(smag3_ff) * CPROD_W'(half_w);
      end
   end

   // Column and size division, both by the depth.
   logic              cv, sv, qc_ovf, qs_ovf;
   logic [CQ_W-1:0]   qc, qs;
   logic [2:0]        c_side;
   logic [2*POS_W-1:0] s_side;

   ssp_div #(.NUM_W(CPROD_W), .DEN_W(TYD_W), .QUO_W(CQ_W), .SIDE_W(3)) u_div_col (
      .clock(clock), .reset(reset), .enable(adv), .in_valid(b4_vld_ff),
      .num(cprod4_ff), .den(den4_ff), .side_in({sing4b_ff, nif4_ff, sneg4_ff}),
      .out_valid(cv), .quot(qc), .ovf(qc_ovf), .side_out(c_side)
   );

   ssp_div #(.NUM_W(SNUM_W), .DEN_W(TYD_W), .QUO_W(CQ_W), .SIDE_W(2*POS_W)) u_div_size (
      .clock(clock), .reset(reset), .enable(adv), .in_valid(b4_vld_ff),
      .num({h_eff, FRAC_BITS'(0)}), .den(den4_ff), .side_in({tx4_ff, ty4_ff}),
      .out_valid(sv), .quot(qs), .ovf(qs_ovf), .side_out(s_side)
   );

   localparam logic [COL_W-1:0] COL_MIN = {1'b1, {(COL_W-1){1'b0}}};
   localparam logic [COL_W-1:0] COL_MAX = {1'b0, {(COL_W-1){1'b1}}};

   logic [COL_W-1:0]  col_sat;
   logic [SIZE_W-1:0] size_sat;

   always_comb begin
      if (c_side[0]) begin
         col_sat = (qc_ovf || (qc[CQ_W-1] && (|qc[CQ_W-2:0]))) ? COL_MIN : (~qc) + COL_W'(1);
      end else begin
         col_sat = (qc_ovf || qc[CQ_W-1]) ? COL_MAX : qc;
      end
      size_sat = (qs_ovf || qs[CQ_W-1]) ? {SIZE_W{1'b1}} : qs[SIZE_W-1:0];
   end

   // C1: saturated column and size.
   logic                     c1_vld_ff, c1_sing_ff, c1_nif_ff;
   logic signed [COL_W-1:0]  c1_col_ff;
   logic [SIZE_W-1:0]        c1_size_ff;
   logic signed [POS_W-1:0]  c1_tx_ff, c1_ty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff <= 1'b0;
      end else if (adv) begin
         c1_vld_ff <= cv && sv;
      end
      if (adv) begin
         c1_col_ff  <= col_sat;
         c1_size_ff <= size_sat;
         c1_sing_ff <= c_side[2];
         c1_nif_ff  <= c_side[1];
         c1_tx_ff   <= s_side[2*POS_W-1:POS_W];
         c1_ty_ff   <= s_side[POS_W-1:0];
      end
   end

   // C2: draw bounds into the output register.
   logic [SIZE_W-2:0]        half_s;
   logic signed [BND_W-1:0]  sx_full, ex_full, w_s;
   logic signed [COL_W-1:0]  ey_full_s;
   logic [SIZE_W-1:0]        sx_in;
   logic signed [COL_W-1:0]  ex_in;
   logic signed [COL_W-1:0]  sy_full;
   logic [SIZE_W:0]          ey_full;
   logic [ROW_W-1:0]         sy_in, ey_in, h_last;
   logic                     zero_out;

   always_comb begin
      half_s   = c1_size_ff[SIZE_W-1:1];
      w_s      = BND_W'(w_eff);
      sx_full  = BND_W'(c1_col_ff) - BND_W'(half_s);
      ex_full  = BND_W'(c1_col_ff) + BND_W'(half_s);
      sx_in    = sx_full[BND_W-1] ? '0 : sx_full[SIZE_W-1:0];
      ex_in    = (ex_full >= w_s) ? COL_W'(w_eff - SCR_W'(1)) : ex_full[COL_W-1:0];
      sy_full  = COL_W'(half_h) - COL_W'(half_s);
      sy_in    = sy_full[COL_W-1] ? '0 : sy_full[ROW_W-1:0];
      ey_full  = (SIZE_W+1)'(half_h) + (SIZE_W+1)'(half_s);
      ey_full_s = COL_W'(ey_full);
      h_last   = ROW_W'(h_eff - SCR_W'(1));
      ey_in    = (ey_full_s >= COL_W'(h_eff)) ? h_last : ey_full[ROW_W-1:0];
      zero_out = c1_sing_ff || c1_nif_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= c1_vld_ff;
      end
      if (adv) begin
         rsp.screen_column   <= zero_out ? '0 : c1_col_ff;
         rsp.sprite_size     <= zero_out ? '0 : c1_size_ff;
         rsp.draw_start_x    <= zero_out ? '0 : sx_in;
         rsp.draw_end_x      <= zero_out ? '0 : ex_in;
         rsp.draw_start_y    <= zero_out ? '0 : sy_in;
         rsp.draw_end_y      <= zero_out ? '0 : ey_in;
         rsp.view_depth      <= zero_out ? '0 : c1_ty_ff;
         rsp.transform_x     <= zero_out ? '0 : c1_tx_ff;
         rsp.camera_singular <= c1_sing_ff;
         rsp.not_in_front    <= c1_nif_ff;
      end
   end

   assign rsp.valid = out_vld_ff;

   `SSP_ASSERT_NEXT(a_take_enters, clock, reset, req.valid && req.ready, s1_vld_ff)
   `SSP_ASSERT_IMPLY(a_singular_clear, clock, reset,
      rsp.valid && rsp.camera_singular,
      !rsp.not_in_front && rsp.sprite_size == '0 && rsp.view_depth == '0)
   `SSP_ASSERT_IMPLY(a_depth_positive, clock, reset,
      rsp.valid && !rsp.camera_singular && !rsp.not_in_front,
      rsp.view_depth > 0 && rsp.draw_end_y <= h_last)
   `SSP_ASSERT_IMPLY(a_rows_ordered, clock, reset,
      rsp.valid && !rsp.camera_singular && !rsp.not_in_front,
      rsp.draw_start_y <= rsp.draw_end_y)

endmodule

// ===== verif/sprite_screen_projection_test.sv =====
// Self-checking testbench for sprite_screen_projection: sprite positions are
// projected by a local fixed-point camera model and each result is compared.
// Depends on ssp_pkg, ssp_req_if, ssp_rsp_if and the block itself.
module sprite_screen_projection_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ssp_pkg::*;

   localparam int DRAIN_CYCLES = 70;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct {
      logic signed [COL_W-1:0] column;
      logic [SIZE_W-1:0]       size;
      logic [SIZE_W-1:0]       start_x;
      logic signed [COL_W-1:0] end_x;
      logic [ROW_W-1:0]        start_y;
      logic [ROW_W-1:0]        end_y;
      logic signed [POS_W-1:0] depth;
      logic signed [POS_W-1:0] lateral;
      logic                    singular;
      logic                    behind;
   } projection_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ssp_req_if req_ch ();
   ssp_rsp_if rsp_ch ();

   sprite_screen_projection dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Camera copy kept in step with every register write.
   logic signed [POS_W-1:0] cam_px, cam_py;
   logic signed [DIR_W-1:0] cam_dx, cam_dy, cam_lx, cam_ly;
   logic [SCR_W-1:0]        cam_w, cam_h;

   projection_type pending_projections[$];
   int errors = 0;
   int cycles = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

   // Truncating division of num * 2^sh by den, magnitude capped at 2^40.
   function automatic longint scaled_quotient(longint num, longint den, int sh);
      longint unsigned cap, n, d, q, r;
      bit neg;
      cap = 64'd1 << 40;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = n / d;
      r = n % d;
      if (q >= cap) q = cap;
      for (int i = 0; i < sh && q < cap; i++) begin
         q = q << 1;
         r = r << 1;
         if (r >= d) begin
            r = r - d;
            q = q | 1;
         end
      end
      if (q > cap) q = cap;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic projection_type project_sprite(logic signed [POS_W-1:0] sx_in,
                                                     logic signed [POS_W-1:0] sy_in);
      projection_type p;
      longint w, h, dx, dy, det, tx, ty, col, size, bx, ex, by, ey;
      p = '{default: '0};
      w = clamp(longint'(cam_w), 1, MAX_SCREEN);
      h = clamp(longint'(cam_h), 1, MAX_SCREEN);
      dx = longint'(sx_in) - longint'(cam_px);
      dy = longint'(sy_in) - longint'(cam_py);
      det = longint'(cam_lx) * longint'(cam_dy) - longint'(cam_dx) * longint'(cam_ly);
      if (det == 0) begin
         p.singular = 1'b1;
         return p;
      end
      tx = scaled_quotient(longint'(cam_dy) * dx - longint'(cam_dx) * dy, det, FRAC_BITS);
      ty = scaled_quotient(longint'(cam_lx) * dy - longint'(cam_ly) * dx, det, FRAC_BITS);
      tx = clamp(tx, -8388608, 8388607);
      ty = clamp(ty, -8388608, 8388607);
      if (ty <= 0) begin
         p.behind = 1'b1;
         return p;
      end
      col = clamp(scaled_quotient((w / 2) * (tx + ty), ty, 0), -524288, 524287);
      size = clamp(scaled_quotient(h, ty, FRAC_BITS), 0, 524287);
      bx = col - size / 2;
      if (bx < 0) bx = 0;
      ex = col + size / 2;
      if (ex >= w) ex = w - 1;
      ex = clamp(ex, -524288, 524287);
      by = h / 2 - size / 2;
      if (by < 0) by = 0;
      ey = h / 2 + size / 2;
      if (ey >= h) ey = h - 1;
      p.column  = col[COL_W-1:0];
      p.size    = size[SIZE_W-1:0];
      p.start_x = bx[SIZE_W-1:0];
      p.end_x   = ex[COL_W-1:0];
      p.start_y = by[ROW_W-1:0];
      p.end_y   = ey[ROW_W-1:0];
      p.depth   = ty[POS_W-1:0];
      p.lateral = tx[POS_W-1:0];
      return p;
   endfunction

   always @(posedge clock) begin
      projection_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_projections.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
         end else begin
            e = pending_projections.pop_front();
            if (rsp_ch.screen_column !== e.column) begin
               $error("screen_column expected %0d actual %0d", e.column, rsp_ch.screen_column);
               errors++;
            end
            if (rsp_ch.sprite_size !== e.size) begin
               $error("sprite_size expected %0d actual %0d", e.size, rsp_ch.sprite_size);
               errors++;
            end
            if (rsp_ch.draw_start_x !== e.start_x) begin
               $error("draw_start_x expected %0d actual %0d", e.start_x, rsp_ch.draw_start_x);
               errors++;
            end
            if (rsp_ch.draw_end_x !== e.end_x) begin
               $error("draw_end_x expected %0d actual %0d", e.end_x, rsp_ch.draw_end_x);
               errors++;
            end
            if (rsp_ch.draw_start_y !== e.start_y) begin
               $error("draw_start_y expected %0d actual %0d", e.start_y, rsp_ch.draw_start_y);
               errors++;
            end
            if (rsp_ch.draw_end_y !== e.end_y) begin
               $error("draw_end_y expected %0d actual %0d", e.end_y, rsp_ch.draw_end_y);
               errors++;
            end
            if (rsp_ch.view_depth !== e.depth) begin
               $error("view_depth expected %0d actual %0d", e.depth, rsp_ch.view_depth);
               errors++;
            end
            if (rsp_ch.transform_x !== e.lateral) begin
               $error("transform_x expected %0d actual %0d", e.lateral, rsp_ch.transform_x);
               errors++;
            end
            if (rsp_ch.camera_singular !== e.singular) begin
               $error("camera_singular expected %0b actual %0b", e.singular,
                      rsp_ch.camera_singular);
               errors++;
            end
            if (rsp_ch.not_in_front !== e.behind) begin
               $error("not_in_front expected %0b actual %0b", e.behind, rsp_ch.not_in_front);
               errors++;
            end
         end
      end
   end

   task automatic send_sprite(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.sprite_x <= x;
      req_ch.sprite_y <= y;
      do @(posedge clock); while (!req_ch.ready);
      pending_projections.push_back(project_sprite(x, y));
   endtask

   // Waits until every result is back and the pipeline has emptied.
   task automatic drain;
      req_ch.valid <= 1'b0;
      while (pending_projections.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Leaves the write enable high; the caller lowers it after the last write.
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_POS_X:   cam_px = value;
         CSR_POS_Y:   cam_py = value;
         CSR_DIR_X:   cam_dx = value[DIR_W-1:0];
         CSR_DIR_Y:   cam_dy = value[DIR_W-1:0];
         CSR_PLANE_X: cam_lx = value[DIR_W-1:0];
         CSR_PLANE_Y: cam_ly = value[DIR_W-1:0];
         CSR_SCR_W:   cam_w = value[SCR_W-1:0];
         CSR_SCR_H:   cam_h = value[SCR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_camera(longint px, longint py, longint dx, longint dy,
                             longint lx, longint ly, int w, int h);
      drain();
      write_reg(CSR_POS_X, px[CSR_DATA_W-1:0]);
      write_reg(CSR_POS_Y, py[CSR_DATA_W-1:0]);
      write_reg(CSR_DIR_X, dx[CSR_DATA_W-1:0]);
      write_reg(CSR_DIR_Y, dy[CSR_DATA_W-1:0]);
      write_reg(CSR_PLANE_X, lx[CSR_DATA_W-1:0]);
      write_reg(CSR_PLANE_Y, ly[CSR_DATA_W-1:0]);
      write_reg(CSR_SCR_W, CSR_DATA_W'(w));
      write_reg(CSR_SCR_H, CSR_DATA_W'(h));
      csr_we <= 1'b0;
   endtask

   function automatic longint rand_signed(int bits);
      longint v;
      v = longint'({$urandom, $urandom}) & ((64'd1 << bits) - 1);
      if (v[bits-1]) v = v - (64'd1 << bits);
      return v;
   endfunction

   task automatic test_reset_camera;
      send_sprite(24'sd0, 24'sd0);
      send_sprite(-24'sd65536, 24'sd0);
      send_sprite(-24'sd131072, 24'sd30000);
      send_sprite(-24'sd8388608, -24'sd8388608);
      send_sprite(24'sd8388607, 24'sd8388607);
      send_sprite(-24'sd8388608, 24'sd8388607);
      send_sprite(-24'sd1, 24'sd0);
   endtask

   task automatic test_extremes;
      // Tiny depth drives size and column into saturation.
      set_camera(0, 0, 65536, 0, 0, 65536, 4096, 4096);
      send_sprite(24'sd1, 24'sd0);
      send_sprite(24'sd1, 24'sd8388607);
      send_sprite(24'sd1, -24'sd8388608);
      send_sprite(24'sd8388607, 24'sd0);
      set_camera(8388607, -8388608, 262143, -262144, -262144, 262143, 8191, 0);
      send_sprite(-24'sd8388608, 24'sd8388607);
      send_sprite(24'sd0, 24'sd0);
      set_camera(-8388608, 8388607, -262144, 1, 1, -262144, 1, 1);
      send_sprite(24'sd8388607, -24'sd8388608);
      send_sprite(24'sd0, 24'sd0);
      set_camera(0, 0, 1, 0, 0, 1, 4097, 0);
      send_sprite(24'sd100, 24'sd3);
   endtask

   task automatic test_singular_camera;
      set_camera(0, 0, 0, 0, 0, 0, 640, 480);
      send_sprite(24'sd65536, 24'sd65536);
      // Parallel direction and plane also give a zero determinant.
      set_camera(12345, -999, 65536, 32768, 131072, 65536, 320, 200);
      send_sprite(-24'sd70000, 24'sd5);
      send_sprite(24'sd8388607, -24'sd8388608);
   endtask

   task automatic random_camera;
      longint d[4];
      int w, h;
      for (int i = 0; i < 4; i++)
         d[i] = ($urandom_range(2) == 0) ? rand_signed(DIR_W) : rand_signed(18);
      if ($urandom_range(9) == 0) begin
         d[2] = d[0] * 2;
         d[3] = d[1] * 2;
         if (d[2] > 262143 || d[2] < -262144 || d[3] > 262143 || d[3] < -262144) begin
            d[2] = d[0];
            d[3] = d[1];
         end
      end
      case ($urandom_range(3))
         0: w = $urandom_range(8191);
         1: w = ($urandom_range(1)) ? 1 : MAX_SCREEN;
         default: w = $urandom_range(1, MAX_SCREEN);
      endcase
      case ($urandom_range(3))
         0: h = $urandom_range(8191);
         1: h = ($urandom_range(1)) ? 1 : MAX_SCREEN;
         default: h = $urandom_range(1, MAX_SCREEN);
      endcase
      set_camera(rand_signed(POS_W), rand_signed(POS_W), d[0], d[1], d[2], d[3], w, h);
   endtask

   task automatic test_random(int idle, int stall, int cameras, int per_camera);
      longint ox, oy;
      idle_pct = idle;
      stall_pct = stall;
      for (int c = 0; c < cameras; c++) begin
         random_camera();
         for (int i = 0; i < per_camera; i++) begin
            if ($urandom_range(9) < 7) begin
               // Near the camera, so most sprites land on screen.
               ox = rand_signed($urandom_range(8, 21));
               oy = rand_signed($urandom_range(8, 21));
               send_sprite(POS_W'(longint'(cam_px) + ox), POS_W'(longint'(cam_py) + oy));
            end else begin
               send_sprite(POS_W'(rand_signed(POS_W)), POS_W'(rand_signed(POS_W)));
            end
            if ($urandom_range(40) == 0) stall_pct = (stall_pct == 0) ? stall : 0;
         end
         stall_pct = stall;
      end
   endtask

   initial begin
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_index     <= CSR_POS_X;
      csr_wdata     <= '0;
      req_ch.valid  <= 1'b0;
      req_ch.sprite_x <= '0;
      req_ch.sprite_y <= '0;
      cam_px = '0;
      cam_py = '0;
      cam_dx = DIR_X_RST;
      cam_dy = '0;
      cam_lx = '0;
      cam_ly = PLANE_Y_RST;
      cam_w  = SCR_W_RST;
      cam_h  = SCR_H_RST;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_camera();
      test_extremes();
      test_singular_camera();
      test_random(0, 0, 5, 35);
      test_random(46, 0, 5, 35);
      test_random(0, 46, 5, 35);
      test_random(19, 19, 5, 35);
      drain();
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
